@@ rtl/core/ntdpe_pkg.sv @@
// ----------------------------------------------------------------------------
// ntdpe_pkg
// Shared types and constants for the nine-tube display pattern engine.
// ----------------------------------------------------------------------------
package ntdpe_pkg;

    localparam int NUM_TUBES   = 9;
    localparam int CHAR_W      = 8;
    localparam int IDX_W       = 16;
    localparam int TICK_W      = 17;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 80;
    localparam int BCD_W       = 20;

    localparam logic [TICK_W-1:0] TICK_MAX   = 17'h1FFFF;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [3:0]        NUM_TUBES_CODE = 4'd9;

    // input kinds
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_LOAD    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // display modes
    localparam logic [2:0] MODE_DIRECT = 3'd0;
    localparam logic [2:0] MODE_SCROLL = 3'd1;
    localparam logic [2:0] MODE_TRIPLE = 3'd2;
    localparam logic [2:0] MODE_NUMBER = 3'd3;
    localparam logic [2:0] MODE_WIPE   = 3'd4;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MODE        = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_DIR    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_INTERVAL    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOTAL_STEPS = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_INDEX = 3'd4;

    localparam logic [IDX_W-1:0] TOTAL_STEPS_RST = 16'd255;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_DIRECT,
        OP_SCROLL,
        OP_TRIPLE,
        OP_NUMBER,
        OP_WIPE
    } t_op;

    typedef logic [NUM_TUBES-1:0][CHAR_W-1:0] t_tubes;

    typedef struct packed {
        t_op                op;
        logic [3:0]         pos;
        logic [CHAR_W-1:0]  chr;
        logic [IDX_W-1:0]   idx;
        logic               done;
        logic [11:0]        cnt_low;
        logic [11:0]        cnt_mid;
        logic [11:0]        cnt_high;
        logic [BCD_W-1:0]   bcd;
        logic [2:0]         mod5;
    } t_item;

endpackage

@@ rtl/core/ntdpe_ctrl.sv @@
// ----------------------------------------------------------------------------
// ntdpe_ctrl
// Input register, configuration registers, tick counter, step index and
// decimal chained counters; issues load and frame operations downstream.
// ----------------------------------------------------------------------------
module ntdpe_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [1:0]                      i_kind,
    input  logic [3:0]                      i_pos,
    input  logic [7:0]                      i_chr,
    output logic                            o_ready,
    input  logic                            i_cfg_wr_en,
    input  logic [ntdpe_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [ntdpe_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                            o_item_valid,
    output ntdpe_pkg::t_item                o_item,
    input  logic                            i_item_ready
);
    import ntdpe_pkg::*;

    logic                r_in_valid;
    logic [1:0]          r_kind;
    logic [3:0]          r_pos;
    logic [CHAR_W-1:0]   r_chr;

    logic [2:0]          r_mode;
    logic                r_step_dir;
    logic [IDX_W-1:0]    r_interval;
    logic [IDX_W-1:0]    r_total;
    logic [IDX_W-1:0]    r_start;

    logic [TICK_W-1:0]   r_elapsed, n_elapsed;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [11:0]         r_low, n_low;
    logic [11:0]         r_mid, n_mid;
    logic [11:0]         r_high, n_high;

    logic [TICK_W-1:0]   tick_inc;
    logic                frame;
    logic                emit;
    logic                leave;
    logic [IDX_W-1:0]    step_idx;
    logic                step_done;
    logic [IDX_W-1:0]    idx_inc;
    logic [IDX_W-1:0]    idx_dec;
    logic [11:0]         tri_low, tri_mid, tri_high;

    function automatic logic [11:0] bcd_inc3(input logic [11:0] v);
        logic [11:0] r;
        r = v;
        if (v[3:0] == 4'd9) begin
            r[3:0] = 4'd0;
            if (v[7:4] == 4'd9) begin
                r[7:4] = 4'd0;
                r[11:8] = (v[11:8] == 4'd9) ? 4'd0 : v[11:8] + 4'd1;
            end else begin
                r[7:4] = v[7:4] + 4'd1;
            end
        end else begin
            r[3:0] = v[3:0] + 4'd1;
        end
        return r;
    endfunction

    always_comb begin
        tick_inc = (r_elapsed < TICK_MAX) ? r_elapsed + 17'd1 : r_elapsed;
        frame    = tick_inc > {1'b0, r_interval};

        idx_inc = r_idx + 16'd1;
        idx_dec = r_idx - 16'd1;
        if (r_step_dir == 1'b0) begin
            step_done = idx_inc >= r_total;
            step_idx  = step_done ? '0 : idx_inc;
        end else begin
            step_done = idx_dec == '0;
            step_idx  = step_done ? r_total - 16'd1 : idx_dec;
        end

        tri_low  = bcd_inc3(r_low);
        tri_mid  = (tri_low[11:8] != 4'd0) ? bcd_inc3(r_mid) : r_mid;
        tri_high = (tri_mid[11:8] != 4'd0) ? bcd_inc3(r_high) : r_high;
        if (tri_low == 12'h999) begin
            tri_low  = '0;
            tri_mid  = '0;
            tri_high = '0;
        end
    end

    always_comb begin
        o_item          = '0;
        o_item.pos      = r_pos;
        o_item.chr      = r_chr;
        o_item.idx      = r_idx;
        o_item.cnt_low  = tri_low;
        o_item.cnt_mid  = tri_mid;
        o_item.cnt_high = tri_high;
        o_item.op       = OP_LOAD;
        emit            = 1'b0;
        case (r_kind)
            KIND_LOAD: begin
                emit = r_pos < NUM_TUBES_CODE;
            end
            KIND_TICK: begin
                if (frame) begin
                    case (r_mode)
                        MODE_DIRECT: begin
                            o_item.op = OP_DIRECT;
                            emit      = 1'b1;
                        end
                        MODE_SCROLL: begin
                            o_item.op = OP_SCROLL;
                            emit      = 1'b1;
                        end
                        MODE_TRIPLE: begin
                            o_item.op = OP_TRIPLE;
                            emit      = 1'b1;
                        end
                        MODE_NUMBER: begin
                            o_item.op   = OP_NUMBER;
                            o_item.done = step_done;
                            emit        = 1'b1;
                        end
                        MODE_WIPE: begin
                            o_item.op   = OP_WIPE;
                            o_item.done = step_done;
                            emit        = 1'b1;
                        end
                        default: begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        o_item_valid = r_in_valid && emit;
        leave        = r_in_valid && (!emit || i_item_ready);
        o_ready      = !r_in_valid || leave;
    end

    always_comb begin
        n_elapsed = r_elapsed;
        n_idx     = r_idx;
        n_low     = r_low;
        n_mid     = r_mid;
        n_high    = r_high;
        if (leave) begin
            case (r_kind)
                KIND_TICK: begin
                    n_elapsed = frame ? '0 : tick_inc;
                    if (frame) begin
                        case (r_mode)
                            MODE_TRIPLE: begin
                                n_low  = tri_low;
                                n_mid  = tri_mid;
                                n_high = tri_high;
                            end
                            MODE_NUMBER, MODE_WIPE: begin
                                n_idx = step_idx;
                            end
                            default: begin
                                n_idx = r_idx;
                            end
                        endcase
                    end
                end
                KIND_RESTART: begin
                    n_idx  = r_start;
                    n_low  = '0;
                    n_mid  = '0;
                    n_high = '0;
                end
                default: begin
                    n_idx = r_idx;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_DIRECT;
            r_step_dir <= 1'b0;
            r_interval <= '0;
            r_total    <= TOTAL_STEPS_RST;
            r_start    <= '0;
            r_elapsed  <= '0;
            r_idx      <= '0;
            r_low      <= '0;
            r_mid      <= '0;
            r_high     <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            r_elapsed <= n_elapsed;
            r_idx     <= n_idx;
            r_low     <= n_low;
            r_mid     <= n_mid;
            r_high    <= n_high;
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_MODE:        r_mode     <= i_cfg_wdata[2:0];
                    CFG_STEP_DIR:    r_step_dir <= i_cfg_wdata[0];
                    CFG_INTERVAL:    r_interval <= i_cfg_wdata;
                    CFG_TOTAL_STEPS: r_total    <= i_cfg_wdata;
                    CFG_START_INDEX: r_start    <= i_cfg_wdata;
                    default: begin
                        r_mode <= r_mode;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_kind <= i_kind;
            r_pos  <= i_pos;
            r_chr  <= i_chr;
        end
    end

endmodule

@@ rtl/core/ntdpe_conv.sv @@
// ----------------------------------------------------------------------------
// ntdpe_conv
// Two-stage binary to decimal conversion of the step index, plus index mod 5.
// ----------------------------------------------------------------------------
module ntdpe_conv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  ntdpe_pkg::t_item i_item,
    output logic             o_ready,
    output logic             o_valid,
    output ntdpe_pkg::t_item o_item,
    input  logic             i_ready
);
    import ntdpe_pkg::*;

    logic   r_a_valid;
    logic   r_b_valid;
    t_item  r_a;
    t_item  r_b;
    t_item  n_b;
    logic   move_a;
    logic   move_b;

    function automatic logic [BCD_W-1:0] dd8(input logic [BCD_W-1:0] bcd,
                                            input logic [7:0] bits);
        logic [BCD_W-1:0] v;
        v = bcd;
        for (int s = 7; s >= 0; s--) begin
            for (int d = 0; d < BCD_W / 4; d++) begin
                if (v[d*4 +: 4] >= 4'd5) begin
                    v[d*4 +: 4] = v[d*4 +: 4] + 4'd3;
                end
            end
            v = {v[BCD_W-2:0], bits[s]};
        end
        return v;
    endfunction

    function automatic logic [2:0] mod5(input logic [IDX_W-1:0] x);
        logic [5:0] s;
        logic [4:0] t;
        s = {2'b00, x[3:0]} + {2'b00, x[7:4]} + {2'b00, x[11:8]} + {2'b00, x[15:12]};
        t = {3'b000, s[5:4]} + {1'b0, s[3:0]};
        if (t >= 5'd15) begin
            t = t - 5'd15;
        end else if (t >= 5'd10) begin
            t = t - 5'd10;
        end else if (t >= 5'd5) begin
            t = t - 5'd5;
        end
        return t[2:0];
    endfunction

    always_comb begin
        n_b      = r_a;
        n_b.bcd  = dd8('0, r_a.idx[15:8]);
        n_b.mod5 = mod5(r_a.idx);

        o_item     = r_b;
        o_item.bcd = dd8(r_b.bcd, r_b.idx[7:0]);
        o_valid    = r_b_valid;

        move_b  = r_b_valid && i_ready;
        move_a  = r_a_valid && (!r_b_valid || move_b);
        o_ready = !r_a_valid || move_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_a_valid <= i_valid;
            end
            if (move_a) begin
                r_b_valid <= 1'b1;
            end else if (move_b) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_a <= i_item;
        end
        if (move_a) begin
            r_b <= n_b;
        end
    end

endmodule

@@ rtl/core/ntdpe_frame.sv @@
// ----------------------------------------------------------------------------
// ntdpe_frame
// Character buffer and output register: applies loads, builds each frame.
// ----------------------------------------------------------------------------
module ntdpe_frame (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ntdpe_pkg::t_item  i_item,
    output logic              o_ready,
    output logic              o_out_valid,
    output ntdpe_pkg::t_tubes o_tubes,
    output logic              o_done,
    input  logic              i_out_ready
);
    import ntdpe_pkg::*;

    t_tubes  r_buf, n_buf;
    t_tubes  r_tubes, n_tubes;
    logic    r_done;
    logic    r_out_valid;
    logic    fire;
    logic    emit;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        return {4'h3, d};
    endfunction

    function automatic logic [CHAR_W-1:0] wipe_char(input logic [2:0] p,
                                                    input int t);
        logic [CHAR_W-1:0] c;
        c = CHAR_SPACE;
        case (p)
            3'd0: if (t == 0) c = 8'h31;
            3'd1: if (t == 1 || t == 3) c = 8'h32;
            3'd2: if (t == 2 || t == 4 || t == 6) c = 8'h33;
            3'd3: if (t == 5 || t == 7) c = 8'h32;
            3'd4: if (t == 8) c = 8'h2B;
            default: c = CHAR_SPACE;
        endcase
        return c;
    endfunction

    always_comb begin
        o_ready = (i_item.op == OP_LOAD) || !r_out_valid || i_out_ready;
        fire    = i_valid && o_ready;
        emit    = i_item.op != OP_LOAD;
        n_buf   = r_buf;
        n_tubes = r_buf;
        case (i_item.op)
            OP_LOAD: begin
                for (int t = 0; t < NUM_TUBES; t++) begin
                    if (i_item.pos == 4'(t)) begin
                        n_buf[t] = i_item.chr;
                    end
                end
            end
            OP_DIRECT: begin
                n_tubes = r_buf;
            end
            OP_SCROLL: begin
                n_buf[0] = r_buf[NUM_TUBES-1];
                for (int t = 1; t < NUM_TUBES; t++) begin
                    n_buf[t] = r_buf[t-1];
                end
                n_tubes = n_buf;
            end
            OP_TRIPLE: begin
                n_tubes[0] = digit_char(i_item.cnt_low[11:8]);
                n_tubes[1] = digit_char(i_item.cnt_low[7:4]);
                n_tubes[2] = digit_char(i_item.cnt_low[3:0]);
                n_tubes[3] = digit_char(i_item.cnt_mid[11:8]);
                n_tubes[4] = digit_char(i_item.cnt_mid[7:4]);
                n_tubes[5] = digit_char(i_item.cnt_mid[3:0]);
                n_tubes[6] = digit_char(i_item.cnt_high[11:8]);
                n_tubes[7] = digit_char(i_item.cnt_high[7:4]);
                n_tubes[8] = digit_char(i_item.cnt_high[3:0]);
            end
            OP_NUMBER: begin
                for (int t = 0; t < NUM_TUBES - BCD_W / 4; t++) begin
                    n_buf[t] = CHAR_ZERO;
                end
                for (int d = 0; d < BCD_W / 4; d++) begin
                    n_buf[NUM_TUBES-1-d] = digit_char(i_item.bcd[d*4 +: 4]);
                end
                n_tubes = n_buf;
            end
            OP_WIPE: begin
                for (int t = 0; t < NUM_TUBES; t++) begin
                    n_tubes[t] = wipe_char(i_item.mod5, t);
                end
            end
            default: begin
                n_tubes = r_buf;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int t = 0; t < NUM_TUBES; t++) begin
                r_buf[t] <= CHAR_SPACE;
            end
        end else begin
            if (fire) begin
                r_buf <= n_buf;
            end
            if (fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_tubes <= n_tubes;
            r_done  <= i_item.done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_tubes     = r_tubes;
    assign o_done      = r_done;

endmodule

@@ rtl/core/nine_tube_display_pattern_engine.sv @@
// ----------------------------------------------------------------------------
// nine_tube_display_pattern_engine
// Frame generator for a nine-character tube display.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one beat per event - a millisecond tick, a buffer
// character load or a restart of the current mode. Output stream (m_axis):
// one beat per frame, carrying nine ASCII characters and a wrap flag.
// Frames are produced on the tick that takes the elapsed count past
// interval_ms; loads, restarts and other ticks give no output beat.
// Configuration: write i_cfg_wdata into register i_cfg_addr while
// i_cfg_wr_en is high (0 mode, 1 step direction, 2 interval, 3 total steps,
// 4 start index). Write only while no beats are in flight.
// Throughput: one input beat per cycle unless m_axis stalls. A frame passes
// from the input register through two decimal conversion stages for the
// step index, then the output register.
// When m_axis stalls, the full frame is held and the stages ahead of it
// keep filling; s_axis deasserts tready once every stage is occupied.
// Reset (synchronous, active low) clears the buffer to spaces, all counters
// to zero, total steps to 255 and empties the pipeline.
// ----------------------------------------------------------------------------
module nine_tube_display_pattern_engine (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // kind[1:0], position[5:2], character[13:6], zero[15:14]
    input  logic [ntdpe_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tube_0[7:0] .. tube_8[71:64], pattern_complete[72], zero[79:73]
    output logic [ntdpe_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    input  logic                             i_cfg_wr_en,
    input  logic [ntdpe_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [ntdpe_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import ntdpe_pkg::*;

    t_item   ctrl_item;
    logic    ctrl_valid;
    logic    conv_ready;
    t_item   conv_item;
    logic    conv_valid;
    logic    frame_ready;
    t_tubes  tubes;
    logic    done;

    ntdpe_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .i_kind       (i_s_axis_tdata[1:0]),
        .i_pos        (i_s_axis_tdata[5:2]),
        .i_chr        (i_s_axis_tdata[13:6]),
        .o_ready      (o_s_axis_tready),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_item_valid (ctrl_valid),
        .o_item       (ctrl_item),
        .i_item_ready (conv_ready)
    );

    ntdpe_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ctrl_valid),
        .i_item  (ctrl_item),
        .o_ready (conv_ready),
        .o_valid (conv_valid),
        .o_item  (conv_item),
        .i_ready (frame_ready)
    );

    ntdpe_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (conv_valid),
        .i_item      (conv_item),
        .o_ready     (frame_ready),
        .o_out_valid (o_m_axis_tvalid),
        .o_tubes     (tubes),
        .o_done      (done),
        .i_out_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {7'd0, done, tubes};

endmodule

@@ sim/ntdpe_frame_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ntdpe_frame_checker
// Watches the event, frame and register channels of the pattern engine.
// Keeps its own copy of the display state, works out the frame that each
// taken event causes and compares every frame beat with the oldest one due.
// ----------------------------------------------------------------------------
module ntdpe_frame_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [ntdpe_pkg::IN_DATA_W-1:0]  i_event_tdata,
    input  logic                             i_event_tvalid,
    input  logic                             i_event_tready,
    input  logic [ntdpe_pkg::OUT_DATA_W-1:0] i_frame_tdata,
    input  logic                             i_frame_tvalid,
    input  logic                             i_frame_tready,
    input  logic                             i_cfg_wr_en,
    input  logic [ntdpe_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [ntdpe_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                               o_fail_count,
    output int                               o_frames_pending
);
    import ntdpe_pkg::*;

    localparam int COUNT_CARRY = 99;
    localparam int COUNT_LIMIT = 999;

    typedef struct {
        t_tubes tubes;
        logic   complete;
    } t_frame;

    t_frame            expected_frames[$];

    logic [2:0]        mode;
    logic              reverse;
    logic [IDX_W-1:0]  interval;
    logic [IDX_W-1:0]  total_steps;
    logic [IDX_W-1:0]  start_index;

    t_tubes            char_buf;
    logic [TICK_W-1:0] elapsed;
    logic [IDX_W-1:0]  step_index;
    logic [9:0]        count_low;
    logic [9:0]        count_mid;
    logic [9:0]        count_high;

    function automatic t_tubes put_decimal(t_tubes tubes, int first, int digits,
                                           int unsigned value);
        int i;
        for (i = digits - 1; i >= 0; i--) begin
            tubes[first + i] = CHAR_ZERO + 8'(value % 10);
            value = value / 10;
        end
        return tubes;
    endfunction

    function automatic t_tubes wipe_pattern(logic [IDX_W-1:0] index);
        t_tubes tubes;
        tubes = {NUM_TUBES{CHAR_SPACE}};
        case (index % 5)
            0: tubes[0] = "1";
            1: begin
                tubes[1] = "2";
                tubes[3] = "2";
            end
            2: begin
                tubes[2] = "3";
                tubes[4] = "3";
                tubes[6] = "3";
            end
            3: begin
                tubes[5] = "2";
                tubes[7] = "2";
            end
            default: tubes[8] = "+";
        endcase
        return tubes;
    endfunction

    function automatic logic advance_index();
        logic wrapped;
        wrapped = 1'b0;
        if (!reverse) begin
            step_index = step_index + 1'b1;
            if (step_index >= total_steps) begin
                step_index = '0;
                wrapped = 1'b1;
            end
        end else begin
            step_index = step_index - 1'b1;
            if (step_index == '0) begin
                step_index = total_steps - 1'b1;
                wrapped = 1'b1;
            end
        end
        return wrapped;
    endfunction

    task automatic apply_event(input logic [IN_DATA_W-1:0] beat);
        logic [1:0]        kind;
        logic [3:0]        pos;
        logic [CHAR_W-1:0] chr;
        t_frame            frame;
        logic              shown;
        kind = beat[1:0];
        pos = beat[5:2];
        chr = beat[13:6];
        shown = 1'b0;
        frame.tubes = '0;
        frame.complete = 1'b0;
        case (kind)
            KIND_LOAD: begin
                if (pos < NUM_TUBES) char_buf[pos] = chr;
            end
            KIND_RESTART: begin
                step_index = start_index;
                count_low = '0;
                count_mid = '0;
                count_high = '0;
            end
            KIND_TICK: begin
                if (elapsed != TICK_MAX) elapsed = elapsed + 1'b1;
                if (elapsed > interval) begin
                    elapsed = '0;
                    shown = 1'b1;
                    case (mode)
                        MODE_DIRECT: frame.tubes = char_buf;
                        MODE_SCROLL: begin
                            char_buf = {char_buf[NUM_TUBES-2:0], char_buf[NUM_TUBES-1]};
                            frame.tubes = char_buf;
                        end
                        MODE_TRIPLE: begin
                            count_low = count_low + 1'b1;
                            if (count_low > COUNT_CARRY) count_mid = count_mid + 1'b1;
                            if (count_mid > COUNT_CARRY) count_high = count_high + 1'b1;
                            if (count_low >= COUNT_LIMIT) begin
                                count_low = '0;
                                count_mid = '0;
                                count_high = '0;
                            end
                            frame.tubes = put_decimal(frame.tubes, 0, 3, count_low);
                            frame.tubes = put_decimal(frame.tubes, 3, 3, count_mid);
                            frame.tubes = put_decimal(frame.tubes, 6, 3, count_high);
                        end
                        MODE_NUMBER: begin
                            char_buf = put_decimal(char_buf, 0, NUM_TUBES, step_index);
                            frame.tubes = char_buf;
                            frame.complete = advance_index();
                        end
                        MODE_WIPE: begin
                            frame.tubes = wipe_pattern(step_index);
                            frame.complete = advance_index();
                        end
                        default: shown = 1'b0;
                    endcase
                end
            end
            default: ;
        endcase
        if (shown) expected_frames.push_back(frame);
    endtask

    task automatic check_frame(input logic [OUT_DATA_W-1:0] beat);
        t_frame want;
        int     i;
        if (expected_frames.size() == 0) begin
            $error("frame beat with no frame due: %h", beat);
            o_fail_count++;
        end else begin
            want = expected_frames.pop_front();
            for (i = 0; i < NUM_TUBES; i++) begin
                if (beat[i*CHAR_W +: CHAR_W] !== want.tubes[i]) begin
                    $error("tube_%0d: expected %02h, got %02h",
                           i, want.tubes[i], beat[i*CHAR_W +: CHAR_W]);
                    o_fail_count++;
                end
            end
            if (beat[NUM_TUBES*CHAR_W] !== want.complete) begin
                $error("pattern_complete: expected %0b, got %0b",
                       want.complete, beat[NUM_TUBES*CHAR_W]);
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode = MODE_DIRECT;
            reverse = 1'b0;
            interval = '0;
            total_steps = TOTAL_STEPS_RST;
            start_index = '0;
            char_buf = {NUM_TUBES{CHAR_SPACE}};
            elapsed = '0;
            step_index = '0;
            count_low = '0;
            count_mid = '0;
            count_high = '0;
            expected_frames.delete();
            o_fail_count = 0;
        end else begin
            if (i_frame_tvalid && i_frame_tready) check_frame(i_frame_tdata);
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_MODE:        mode = i_cfg_wdata[2:0];
                    CFG_STEP_DIR:    reverse = i_cfg_wdata[0];
                    CFG_INTERVAL:    interval = i_cfg_wdata;
                    CFG_TOTAL_STEPS: total_steps = i_cfg_wdata;
                    CFG_START_INDEX: start_index = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_event_tvalid && i_event_tready) apply_event(i_event_tdata);
        end
        o_frames_pending = expected_frames.size();
    end

endmodule

@@ sim/nine_tube_display_pattern_engine_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nine_tube_display_pattern_engine_test
// Drives ticks, character loads and restarts into the pattern engine through
// a series of register settings, with random gaps and stalls on both
// streams, and reports the verdict from the frame checker.
// ----------------------------------------------------------------------------
module nine_tube_display_pattern_engine_test;
    import ntdpe_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 120;

    localparam logic [1:0] KIND_UNUSED    = 2'd3;
    localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
    localparam logic       DIR_FORWARD    = 1'b0;
    localparam logic       DIR_REVERSE    = 1'b1;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    int fail_count;
    int frames_pending;
    int cycle_count = 0;
    bit steady = 1'b0;
    bit gappy = 1'b0;
    bit hold_req = 1'b0;

    nine_tube_display_pattern_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    ntdpe_frame_checker frame_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_event_tdata    (i_s_axis_tdata),
        .i_event_tvalid   (i_s_axis_tvalid),
        .i_event_tready   (o_s_axis_tready),
        .i_frame_tdata    (o_m_axis_tdata),
        .i_frame_tvalid   (o_m_axis_tvalid),
        .i_frame_tready   (i_m_axis_tready),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_fail_count     (fail_count),
        .o_frames_pending (frames_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // hold off for a long stretch on request, otherwise stall in random bursts
    initial begin : frame_sink
        forever begin
            if (hold_req) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    task automatic send_event(input logic [1:0] kind, input logic [3:0] pos,
                              input logic [7:0] chr);
        if (gappy && !steady && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_s_axis_tdata <= {2'b00, chr, pos, kind};
        i_s_axis_tvalid <= 1'b1;
        @(negedge i_clk);
        while (!o_s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (frames_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [2:0] mode, input logic dir,
                             input logic [15:0] interval, input logic [15:0] total,
                             input logic [15:0] start);
        settle();
        write_register(CFG_MODE, 16'(mode));
        write_register(CFG_STEP_DIR, 16'(dir));
        write_register(CFG_INTERVAL, interval);
        write_register(CFG_TOTAL_STEPS, total);
        write_register(CFG_START_INDEX, start);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_random_event();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            send_event(KIND_TICK, 4'($urandom_range(0, 15)), 8'($urandom));
        end else if (pick < 88) begin
            if ($urandom_range(0, 7) == 0)
                send_event(KIND_LOAD, 4'($urandom_range(9, 15)), 8'($urandom));
            else
                send_event(KIND_LOAD, 4'($urandom_range(0, 8)), 8'($urandom));
        end else if (pick < 97) begin
            send_event(KIND_RESTART, 4'($urandom_range(0, 15)), 8'($urandom));
        end else begin
            send_event(KIND_UNUSED, 4'($urandom_range(0, 15)), 8'($urandom));
        end
    endtask

    task automatic run_random_phase(input int n_events);
        logic [2:0]  mode;
        logic        dir;
        logic [15:0] interval;
        logic [15:0] total;
        logic [15:0] start;
        int          i;
        if ($urandom_range(0, 9) == 0)
            mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
        else
            mode = 3'($urandom_range(MODE_DIRECT, MODE_WIPE));
        dir = $urandom_range(0, 1) ? DIR_REVERSE : DIR_FORWARD;
        interval = ($urandom_range(0, 9) < 6) ? 16'd0 : 16'($urandom_range(1, 4));
        case ($urandom_range(0, 7))
            0: total = 16'd0;
            1: total = 16'd1;
            2: total = 16'hFFFF;
            default: total = 16'($urandom_range(2, 12));
        endcase
        case ($urandom_range(0, 5))
            0: start = 16'hFFFF;
            1: start = 16'd0;
            default: start = 16'($urandom_range(0, 14));
        endcase
        configure(mode, dir, interval, total, start);
        gappy = $urandom_range(0, 2) != 0;
        for (i = 0; i < n_events; i++) send_random_event();
    endtask

    initial begin : stimulus
        int i;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // direct mode after reset: fill the buffer, try dropped loads
        send_event(KIND_LOAD, 4'd0, 8'h00);
        for (i = 1; i < NUM_TUBES - 1; i++) send_event(KIND_LOAD, 4'(i), 8'h40 + 8'(i));
        send_event(KIND_LOAD, 4'd8, 8'hFF);
        send_event(KIND_LOAD, 4'd9, 8'h55);
        send_event(KIND_LOAD, 4'd15, 8'hAA);
        send_event(KIND_UNUSED, 4'd15, 8'hFF);
        send_event(KIND_TICK, 4'd0, 8'h00);

        configure(MODE_SCROLL, DIR_FORWARD, 16'd0, 16'd255, 16'd0);
        send_event(KIND_TICK, 4'd0, 8'h00);
        send_event(KIND_TICK, 4'd15, 8'hFF);

        configure(MODE_TRIPLE, DIR_FORWARD, 16'd0, 16'd255, 16'd0);
        send_event(KIND_TICK, 4'd0, 8'h00);
        send_event(KIND_RESTART, 4'd0, 8'h00);
        send_event(KIND_TICK, 4'd0, 8'h00);

        configure(MODE_NUMBER, DIR_REVERSE, 16'd0, 16'd3, 16'd1);
        send_event(KIND_RESTART, 4'd0, 8'h00);
        send_event(KIND_TICK, 4'd0, 8'h00);
        send_event(KIND_TICK, 4'd0, 8'h00);

        configure(MODE_WIPE, DIR_FORWARD, 16'd0, 16'd0, 16'hFFFF);
        send_event(KIND_RESTART, 4'd0, 8'h00);
        send_event(KIND_TICK, 4'd0, 8'h00);
        send_event(KIND_TICK, 4'd0, 8'h00);

        configure(MODE_UNUSED_LO, DIR_FORWARD, 16'd0, 16'd255, 16'd0);
        send_event(KIND_TICK, 4'd0, 8'h00);

        // index wrap at the top of the range, then reverse from zero
        configure(MODE_NUMBER, DIR_FORWARD, 16'd0, 16'hFFFF, 16'hFFFE);
        send_event(KIND_RESTART, 4'd0, 8'h00);
        for (i = 0; i < 4; i++) send_event(KIND_TICK, 4'd0, 8'h00);
        configure(MODE_NUMBER, DIR_REVERSE, 16'd1, 16'hFFFF, 16'd0);
        send_event(KIND_RESTART, 4'd0, 8'h00);
        for (i = 0; i < 6; i++) send_event(KIND_TICK, 4'd0, 8'h00);

        // longest interval: ticks accumulate without a frame
        configure(MODE_DIRECT, DIR_FORWARD, 16'hFFFF, 16'd5, 16'd3);
        gappy = 1'b1;
        for (i = 0; i < 20; i++) send_random_event();

        // hold the frame side off while ticks keep coming
        configure(MODE_DIRECT, DIR_FORWARD, 16'd0, 16'd255, 16'd0);
        gappy = 1'b0;
        hold_req = 1'b1;
        for (i = 0; i < 40; i++) send_event(KIND_TICK, 4'($urandom), 8'($urandom));

        for (i = 0; i < 10; i++) run_random_phase($urandom_range(15, 30));

        // no idling from here on; run the chained counters through rollover
        steady = 1'b1;
        configure(MODE_TRIPLE, DIR_FORWARD, 16'd0, 16'd255, 16'd0);
        send_event(KIND_RESTART, 4'd0, 8'h00);
        for (i = 0; i < 1060; i++) begin
            if (i % 20 == 19)
                send_event(KIND_LOAD, 4'($urandom_range(0, 8)), 8'($urandom));
            else
                send_event(KIND_TICK, 4'($urandom), 8'($urandom));
        end

        settle();
        if (fail_count == 0 && frames_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
